@@ hw/rtl/efst_pkg.sv @@
package efst_pkg;

    localparam int DW = 32;
    localparam int FB = 16;
    localparam int NW = 4;
    localparam int N_SAT = DW - 1 - FB;
    localparam int RW = 16;
    localparam int AW = 20;
    localparam int TW = 18;
    localparam int NTERMS = 9;

    typedef logic signed [DW-1:0] t_q;
    typedef logic [5:0][DW-1:0] t_vec;
    typedef logic [30:0] t_gain;
    typedef logic [1:0] t_cfg_idx;
    typedef logic [2:0] t_row;

    localparam t_q Q_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam t_q Q_MIN = {1'b1, {(DW-1){1'b0}}};
    localparam t_q Q_ONE = t_q'(1 << FB);
    localparam t_q Q_NEG_ONE = -Q_ONE;
    localparam logic [RW-1:0] LN2Q = 16'hB172;

    localparam t_cfg_idx CFG_GAIN_T = 2'd0;
    localparam t_cfg_idx CFG_RATE_T = 2'd1;
    localparam t_cfg_idx CFG_GAIN_C = 2'd2;
    localparam t_cfg_idx CFG_RATE_C = 2'd3;

    localparam t_row ROW_FIRST = 3'd0;
    localparam t_row ROW_LAST = 3'd5;

    typedef struct packed {
        t_gain gain_tension;
        t_gain exp_rate_tension;
        t_gain gain_compression;
        t_gain exp_rate_compression;
    } t_cfg;

    typedef struct packed {
        t_q c_xx;
        t_q c_yy;
        t_q c_zz;
        t_q c_xy;
        t_q c_yz;
        t_q c_xz;
        t_q a_xx;
        t_q a_yy;
        t_q a_zz;
        t_q a_xy;
        t_q a_yz;
        t_q a_xz;
    } t_in;

    typedef struct packed {
        t_row row_index;
        t_q stress_part;
        t_q tangent_0;
        t_q tangent_1;
        t_q tangent_2;
        t_q tangent_3;
        t_q tangent_4;
        t_q tangent_5;
        logic last_row;
    } t_out;

    function automatic t_vec in_c(t_in d);
        in_c = {d.c_xz, d.c_yz, d.c_xy, d.c_zz, d.c_yy, d.c_xx};
    endfunction

    function automatic t_vec in_a(t_in d);
        in_a = {d.a_xz, d.a_yz, d.a_xy, d.a_zz, d.a_yy, d.a_xx};
    endfunction

    // saturating add
    function automatic t_q sadd(t_q a, t_q b);
        logic [DW:0] s;
        s = {a[DW-1], a} + {b[DW-1], b};
        if (s[DW] != s[DW-1]) begin
            sadd = s[DW] ? Q_MIN : Q_MAX;
        end else begin
            sadd = t_q'(s[DW-1:0]);
        end
    endfunction

    // sign-magnitude multiply, truncate toward zero, saturate
    function automatic t_q smul(t_q a, t_q b);
        logic [DW-1:0] ua;
        logic [DW-1:0] ub;
        logic [2*DW-1:0] pr;
        logic [2*DW-FB-1:0] m;
        logic ng;
        ua = a[DW-1] ? DW'(~a + 1'b1) : DW'(a);
        ub = b[DW-1] ? DW'(~b + 1'b1) : DW'(b);
        pr = (2*DW)'(ua) * (2*DW)'(ub);
        m = pr[2*DW-1:FB];
        ng = a[DW-1] ^ b[DW-1];
        if (m > (2*DW-FB)'(Q_MAX)) begin
            smul = ng ? Q_MIN : Q_MAX;
        end else begin
            smul = ng ? t_q'(~m[DW-1:0] + 1'b1) : t_q'(m[DW-1:0]);
        end
    endfunction

endpackage

@@ hw/rtl/efst_fifo.sv @@
module efst_fifo
    import efst_pkg::*;
#(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_full,
    output logic             o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;

    function automatic logic [PW-1:0] nxt(logic [PW-1:0] p);
        nxt = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= nxt(r_wr);
            end
            if (i_pop) begin
                r_rd <= nxt(r_rd);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_wdata;
        end
    end

    assign o_rdata = r_mem[r_rd];
    assign o_full = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);

endmodule

@@ hw/rtl/efst_front.sv @@
module efst_front
    import efst_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_in  i_data,
    input  t_cfg i_cfg,
    output logic o_valid,
    output t_q   o_gamma,
    output t_q   o_delta
);

    localparam int NSTAGE = 10 + 2 * NTERMS;

    typedef struct packed {
        logic [TW-1:0] term;
        logic [TW-1:0] sum;
        logic [RW-1:0] r;
        logic [NW-1:0] n;
        logic sat;
        t_q g;
        t_q pk;
    } t_tay;

    logic [NSTAGE-1:0] r_vsr;

    t_vec w_c;
    t_vec w_a;
    t_vec r_p1;
    t_vec r_p2;
    t_q r_s2;
    t_q r_i4;
    t_q r_d;
    t_q r_k1_4;
    t_q r_k2_4;
    t_q r_dd;
    t_q r_g0;
    t_q r_k1_5;
    t_q r_k2_5;
    t_q r_arg;
    t_q r_g6;
    t_q r_k1_6;
    logic [NW-1:0] w_n;
    logic w_sat;
    logic [RW-1:0] w_r;
    logic [NW-1:0] r_n7;
    logic [RW-1:0] r_r7;
    logic r_sat7;
    t_q r_p07;
    t_q r_g7;
    t_q r_k1_7;
    t_tay r_ta [NTERMS+1];
    t_tay r_tm [1:NTERMS];
    logic [TW+N_SAT-1:0] w_ew;
    t_q w_p;
    t_q r_e;
    t_q r_p9;
    t_q r_g9;
    t_q r_gamma;
    t_q r_delta;

    assign w_c = in_c(i_data);
    assign w_a = in_a(i_data);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vsr <= '0;
        end else begin
            r_vsr <= {r_vsr[NSTAGE-2:0], i_valid};
        end
    end

    // dot product and range reduction
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 6; i++) begin
            r_p1[i] <= smul(w_c[i], w_a[i]);
        end
        r_p2 <= r_p1;
        r_s2 <= sadd(sadd(sadd(r_p1[0], r_p1[1]), r_p1[2]), r_p1[3]);
        r_i4 <= sadd(sadd(r_s2, r_p2[4]), r_p2[5]);
        r_d <= sadd(r_i4, Q_NEG_ONE);
        if (r_i4 < Q_ONE) begin
            r_k1_4 <= t_q'({1'b0, i_cfg.gain_compression});
            r_k2_4 <= t_q'({1'b0, i_cfg.exp_rate_compression});
        end else begin
            r_k1_4 <= t_q'({1'b0, i_cfg.gain_tension});
            r_k2_4 <= t_q'({1'b0, i_cfg.exp_rate_tension});
        end
        r_dd <= smul(r_d, r_d);
        r_g0 <= smul(r_k1_4, r_d);
        r_k1_5 <= r_k1_4;
        r_k2_5 <= r_k2_4;
        r_arg <= smul(r_k2_5, r_dd);
        r_g6 <= sadd(r_g0, r_g0);
        r_k1_6 <= r_k1_5;
        r_n7 <= w_n;
        r_r7 <= w_r;
        r_sat7 <= w_sat;
        r_p07 <= sadd(Q_ONE, sadd(r_arg, r_arg));
        r_g7 <= r_g6;
        r_k1_7 <= r_k1_6;
    end

    // arg = n*ln2 + r, n found by compares against constant multiples
    always_comb begin
        w_n = '0;
        for (int m = 1; m < N_SAT; m++) begin
            if (r_arg >= t_q'(m * LN2Q)) begin
                w_n = w_n + 1'b1;
            end
        end
        w_sat = (r_arg >= t_q'(N_SAT * LN2Q));
        w_r = RW'(r_arg[AW-1:0] - AW'(w_n) * AW'(LN2Q));
    end

    always_ff @(posedge i_clk) begin
        r_ta[0].term <= TW'(Q_ONE);
        r_ta[0].sum <= TW'(Q_ONE);
        r_ta[0].r <= r_r7;
        r_ta[0].n <= r_n7;
        r_ta[0].sat <= r_sat7;
        r_ta[0].g <= r_g7;
        r_ta[0].pk <= smul(r_p07, r_k1_7);
    end

    // taylor series, two stages per term: multiply by r, then divide by k
    // through a multiply by the rounded-up reciprocal
    for (genvar k = 1; k <= NTERMS; k++) begin : g_tay
        localparam int K = k;
        localparam int RS = TW + 4;
        localparam logic [RS:0] RECIP = (RS+1)'(((1 << RS) + K - 1) / K);
        logic [TW+RW-1:0] w_pr;
        logic [TW+RS:0] w_q;
        logic [TW-1:0] w_t;
        t_tay n_tm;
        t_tay n_ta;
        assign w_pr = (TW+RW)'(r_ta[k-1].term) * (TW+RW)'(r_ta[k-1].r);
        assign w_q = (TW+RS+1)'(r_tm[k].term) * (TW+RS+1)'(RECIP);
        assign w_t = TW'(w_q >> RS);
        always_comb begin
            n_tm = r_ta[k-1];
            n_tm.term = TW'(w_pr >> FB);
            n_ta = r_tm[k];
            n_ta.term = w_t;
            n_ta.sum = r_tm[k].sum + w_t;
        end
        always_ff @(posedge i_clk) begin
            r_tm[k] <= n_tm;
            r_ta[k] <= n_ta;
        end
    end

    assign w_ew = (TW+N_SAT)'(r_ta[NTERMS].sum) << r_ta[NTERMS].n;
    assign w_p = sadd(r_ta[NTERMS].pk, r_ta[NTERMS].pk);

    always_ff @(posedge i_clk) begin
        if (r_ta[NTERMS].sat || (w_ew > (TW+N_SAT)'(Q_MAX))) begin
            r_e <= Q_MAX;
        end else begin
            r_e <= t_q'(w_ew[DW-1:0]);
        end
        r_p9 <= sadd(w_p, w_p);
        r_g9 <= r_ta[NTERMS].g;
        r_gamma <= smul(r_g9, r_e);
        r_delta <= smul(r_p9, r_e);
    end

    assign o_valid = r_vsr[NSTAGE-1];
    assign o_gamma = r_gamma;
    assign o_delta = r_delta;

endmodule

@@ hw/rtl/efst_back.sv @@
module efst_back
    import efst_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_avail,
    input  t_q   i_gamma,
    input  t_q   i_delta,
    input  t_vec i_avec,
    output logic o_pop,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);

    logic w_adv;
    logic w_take;
    logic r_busy;
    t_row r_row;
    t_q r_gamma;
    t_q r_delta;
    t_vec r_a;
    logic r_s1v;
    t_row r_s1_row;
    t_q r_s1_stress;
    t_q r_s1_dr;
    t_vec r_s1_a;
    logic r_ov;
    t_out r_out;

    assign w_adv = !r_ov || i_ready;
    assign w_take = w_adv && i_avail && (!r_busy || (r_row == ROW_LAST));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_row <= ROW_FIRST;
            r_s1v <= 1'b0;
            r_ov <= 1'b0;
        end else if (w_adv) begin
            r_ov <= r_s1v;
            r_s1v <= r_busy;
            if (w_take) begin
                r_busy <= 1'b1;
                r_row <= ROW_FIRST;
            end else if (r_busy) begin
                if (r_row == ROW_LAST) begin
                    r_busy <= 1'b0;
                end else begin
                    r_row <= r_row + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_gamma <= i_gamma;
            r_delta <= i_delta;
            r_a <= i_avec;
        end
        if (w_adv) begin
            r_s1_row <= r_row;
            r_s1_stress <= smul(r_gamma, r_a[r_row]);
            r_s1_dr <= smul(r_delta, r_a[r_row]);
            r_s1_a <= r_a;
            r_out.row_index <= r_s1_row;
            r_out.stress_part <= r_s1_stress;
            r_out.tangent_0 <= smul(r_s1_dr, r_s1_a[0]);
            r_out.tangent_1 <= smul(r_s1_dr, r_s1_a[1]);
            r_out.tangent_2 <= smul(r_s1_dr, r_s1_a[2]);
            r_out.tangent_3 <= smul(r_s1_dr, r_s1_a[3]);
            r_out.tangent_4 <= smul(r_s1_dr, r_s1_a[4]);
            r_out.tangent_5 <= smul(r_s1_dr, r_s1_a[5]);
            r_out.last_row <= (r_s1_row == ROW_LAST);
        end
    end

    assign o_pop = w_take;
    assign o_valid = r_ov;
    assign o_data = r_out;

endmodule

@@ hw/rtl/exp_fiber_stress_tangent.sv @@
// exponential fiber stress and tangent rows, signed q16.16
// input channel i_valid/o_ready/i_data: one request carries the six voigt
// components of c and of the fiber tensor a
// output channel o_valid/i_ready/o_data: six rows per request, row_index
// 0 to 5, last_row set on row 5
// config: i_cfg_we writes i_cfg_data into register i_cfg_idx at once
// (0 tension gain, 1 tension rate, 2 compression gain, 3 compression rate)
// rows: the first row of a request is followed by the remaining five, one
// per cycle while i_ready is high; the row emitter takes a new request only
// as it emits the last row of the one before, and the scalar pipeline takes
// a request each cycle
// two queues of QUEUE_DEPTH entries each hold fiber vectors and scalar
// results between the pipeline and the row emitter
// reset clears the queues, the pipeline valids and all config registers
// when i_ready is low the output row holds; o_ready drops once the fiber
// vector queue has QUEUE_DEPTH requests in flight
module exp_fiber_stress_tangent
    import efst_pkg::*;
#(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in      i_data,
    output logic     o_valid,
    input  logic     i_ready,
    output t_out     o_data,
    input  logic     i_cfg_we,
    input  t_cfg_idx i_cfg_idx,
    input  t_gain    i_cfg_data
);

    t_cfg r_cfg;
    logic w_acc;
    logic w_pop;
    logic aq_full;
    logic aq_empty;
    t_vec aq_rdata;
    logic sq_push;
    logic sq_full;
    logic sq_empty;
    t_q f_gamma;
    t_q f_delta;
    logic [2*DW-1:0] sq_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GAIN_T: r_cfg.gain_tension <= i_cfg_data;
                CFG_RATE_T: r_cfg.exp_rate_tension <= i_cfg_data;
                CFG_GAIN_C: r_cfg.gain_compression <= i_cfg_data;
                CFG_RATE_C: r_cfg.exp_rate_compression <= i_cfg_data;
                default: r_cfg <= r_cfg;
            endcase
        end
    end

    assign o_ready = !aq_full;
    assign w_acc = i_valid && o_ready;

    // fiber vector waits here while its scalars are computed
    efst_fifo #(
        .WIDTH($bits(t_vec)),
        .DEPTH(QUEUE_DEPTH)
    ) u_aq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_acc),
        .i_wdata(in_a(i_data)),
        .i_pop  (w_pop),
        .o_rdata(aq_rdata),
        .o_full (aq_full),
        .o_empty(aq_empty)
    );

    efst_front u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(w_acc),
        .i_data (i_data),
        .i_cfg  (r_cfg),
        .o_valid(sq_push),
        .o_gamma(f_gamma),
        .o_delta(f_delta)
    );

    efst_fifo #(
        .WIDTH(2 * DW),
        .DEPTH(QUEUE_DEPTH)
    ) u_sq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (sq_push),
        .i_wdata({f_gamma, f_delta}),
        .i_pop  (w_pop),
        .o_rdata(sq_rdata),
        .o_full (sq_full),
        .o_empty(sq_empty)
    );

    efst_back u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_avail(!sq_empty),
        .i_gamma(t_q'(sq_rdata[2*DW-1:DW])),
        .i_delta(t_q'(sq_rdata[DW-1:0])),
        .i_avec (aq_rdata),
        .o_pop  (w_pop),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_data (o_data)
    );

    a_sq_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(sq_push && sq_full && !w_pop))
        else $error("scalar queue overflow");

    a_sq_behind_aq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !sq_empty |-> !aq_empty)
        else $error("scalar result without fiber vector");

    a_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.last_row == (o_data.row_index == ROW_LAST)))
        else $error("last_row flag does not match row index");

endmodule
